// File: rtl/core/pbvs_pkg.sv
// Shared types, constants and width helpers for the paletted voxel store.
// Used by pbvs_repack and the top level; depends on nothing.
`default_nettype none
package pbvs_pkg;

    localparam int CELL_COUNT    = 4096;
    localparam int WORD_COUNT    = 1024;
    localparam int PALETTE_DEPTH = 256;
    localparam int WORD_W        = 64;
    localparam int SID_W         = 15;
    localparam int BITS_W        = 4;
    localparam int CELL_W        = $clog2(CELL_COUNT);
    localparam int WADDR_W       = $clog2(WORD_COUNT);
    localparam int MADDR_W       = WADDR_W + 1;
    localparam int PAL_W         = $clog2(PALETTE_DEPTH);
    localparam int PSIZE_W       = PAL_W + 1;
    localparam int OFF_W         = $clog2(WORD_W);
    localparam int RECIP_SHIFT   = 20;
    localparam int RECIP_W       = 19;
    localparam int CLEAR_WORDS   = CELL_COUNT / (WORD_W / 4);

    localparam logic [BITS_W-1:0] MIN_BITS    = 4'd4;
    localparam logic [BITS_W-1:0] DIRECT_BITS = 4'd15;

    typedef struct packed {
        logic [BITS_W-1:0]  src_bits;
        logic [BITS_W-1:0]  dst_bits;
        logic               resolve;
        logic               src_bank;
        logic [PSIZE_W-1:0] psize;
    } t_repack_cfg;

    typedef struct packed {
        logic [MADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [MADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
        logic [PAL_W-1:0]   pal_addr;
    } t_repack_req;

    function automatic logic [4:0] cells_per_word(input logic [BITS_W-1:0] bits);
        logic [4:0] per;
        case (bits)
            4'd4:    per = 5'd16;
            4'd5:    per = 5'd12;
            4'd6:    per = 5'd10;
            4'd7:    per = 5'd9;
            4'd8:    per = 5'd8;
            default: per = 5'd4;
        endcase
        return per;
    endfunction

    // Rounded-up reciprocal of the cells per word, scaled by 2^RECIP_SHIFT.
    function automatic logic [RECIP_W-1:0] word_recip(input logic [BITS_W-1:0] bits);
        logic [RECIP_W-1:0] m;
        case (bits)
            4'd4:    m = 19'd65536;
            4'd5:    m = 19'd87382;
            4'd6:    m = 19'd104858;
            4'd7:    m = 19'd116509;
            4'd8:    m = 19'd131072;
            default: m = 19'd262144;
        endcase
        return m;
    endfunction

    function automatic logic [BITS_W-1:0] need_bits(input logic [PSIZE_W-1:0] size);
        logic [BITS_W-1:0] b;
        if (size <= 9'd16) begin
            b = 4'd4;
        end else if (size <= 9'd32) begin
            b = 4'd5;
        end else if (size <= 9'd64) begin
            b = 4'd6;
        end else if (size <= 9'd128) begin
            b = 4'd7;
        end else begin
            b = 4'd8;
        end
        return b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/pbvs_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
// Depends on nothing.
`default_nettype none
module pbvs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule
`default_nettype wire

// File: rtl/core/pbvs_repack.sv
// Repack engine: streams every cell from one word bank into the other bank
// at a new width, optionally resolving palette indexes. Depends on pbvs_pkg.
`default_nettype none
module pbvs_repack (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire pbvs_pkg::t_repack_cfg      i_cfg,
    input  wire logic [pbvs_pkg::WORD_W-1:0] i_word_q,
    input  wire logic [pbvs_pkg::SID_W-1:0]  i_pal_q,
    output pbvs_pkg::t_repack_req           o_req,
    output logic                            o_done
);

    pbvs_pkg::t_repack_cfg r_cfg;
    logic                                r_run;
    logic [pbvs_pkg::CELL_W-1:0]         r_ci;
    logic [pbvs_pkg::WADDR_W-1:0]        r_sw;
    logic [3:0]                          r_ss;
    logic                                r_v1;
    logic                                r_last1;
    logic [pbvs_pkg::OFF_W-1:0]          r_off1;
    logic                                r_v2;
    logic                                r_last2;
    logic [pbvs_pkg::SID_W-1:0]          r_field2;
    logic                                r_ok2;
    logic [pbvs_pkg::WADDR_W-1:0]        r_dw;
    logic [3:0]                          r_ds;
    logic [pbvs_pkg::WORD_W-1:0]         r_acc;
    logic                                r_done;

    logic [4:0]                          w_sper;
    logic [4:0]                          w_dper;
    logic [7:0]                          w_soff;
    logic [7:0]                          w_doff;
    logic [pbvs_pkg::WORD_W-1:0]         w_smask;
    logic [pbvs_pkg::SID_W-1:0]          w_field;
    logic [pbvs_pkg::SID_W-1:0]          w_val;
    logic [pbvs_pkg::WORD_W-1:0]         w_word;
    logic                                w_flush;

    always_comb begin
        w_sper  = pbvs_pkg::cells_per_word(r_cfg.src_bits);
        w_dper  = pbvs_pkg::cells_per_word(r_cfg.dst_bits);
        w_soff  = r_ss * r_cfg.src_bits;
        w_doff  = r_ds * r_cfg.dst_bits;
        w_smask = ~({pbvs_pkg::WORD_W{1'b1}} << r_cfg.src_bits);
        w_field = pbvs_pkg::SID_W'((i_word_q >> r_off1) & w_smask);
        w_val   = r_cfg.resolve ? (r_ok2 ? i_pal_q : '0) : r_field2;
        w_word  = r_acc | (pbvs_pkg::WORD_W'(w_val) << w_doff[pbvs_pkg::OFF_W-1:0]);
        w_flush = r_v2 && ((5'(r_ds) == w_dper - 5'd1) || r_last2);

        o_req.rd_addr  = {r_cfg.src_bank, r_sw};
        o_req.wr_en    = w_flush;
        o_req.wr_addr  = {~r_cfg.src_bank, r_dw};
        o_req.wr_data  = w_word;
        o_req.pal_addr = w_field[pbvs_pkg::PAL_W-1:0];
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_v2 && r_last2;
            r_v1   <= r_run;
            r_v2   <= r_v1;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_ci == pbvs_pkg::CELL_W'(pbvs_pkg::CELL_COUNT - 1))) begin
                r_run <= 1'b0;
            end
        end

        if (i_start) begin
            r_cfg <= i_cfg;
            r_ci  <= '0;
            r_sw  <= '0;
            r_ss  <= '0;
            r_dw  <= '0;
            r_ds  <= '0;
            r_acc <= '0;
        end else begin
            if (r_run) begin
                r_ci <= r_ci + 1'b1;
                if (5'(r_ss) == w_sper - 5'd1) begin
                    r_ss <= '0;
                    r_sw <= r_sw + 1'b1;
                end else begin
                    r_ss <= r_ss + 1'b1;
                end
            end
            if (r_v2) begin
                if (w_flush) begin
                    r_acc <= '0;
                    r_ds  <= '0;
                    r_dw  <= r_dw + 1'b1;
                end else begin
                    r_acc <= w_word;
                    r_ds  <= r_ds + 1'b1;
                end
            end
        end

        r_last1  <= r_run && (r_ci == pbvs_pkg::CELL_W'(pbvs_pkg::CELL_COUNT - 1));
        r_off1   <= w_soff[pbvs_pkg::OFF_W-1:0];
        r_last2  <= r_last1;
        r_field2 <= w_field;
        r_ok2    <= 9'(w_field) < r_cfg.psize;
    end

endmodule
`default_nettype wire

// File: rtl/core/paletted_bitpacked_voxel_store.sv
// Top level of the paletted bit-packed voxel store: command FSM, word and
// palette memories and the repack engine. Depends on pbvs_pkg, pbvs_ram, pbvs_repack.
//
// A command is transferred when start is high and busy is low. Each command
// returns one result on the o_ ports, marked by o_valid for exactly one
// cycle; the receiver cannot stall it.
// After reset the block runs a clearing pass over the first 256 packed words
// of bank 0, holding busy high, and then starts with a 16-entry-per-word layout
// and a palette holding only state 0.
// Reads and direct-mode writes pass through S_ADDR, S_OFF and S_MOD, and a
// read that needs a palette lookup also through S_PAL. Palette writes search
// the palette memory one entry at a time, reading it in S_SRCH and comparing
// it in S_CMP; a write that does not find its state appends it. When the
// palette outgrows the current width, or overflows into direct mode, all 4096
// cells are repacked into the other word bank at one cell per cycle.
// The word memory port sets the pace: one access per cycle.
`default_nettype none
module paletted_bitpacked_voxel_store (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_func,
    input  wire logic [3:0]  i_x,
    input  wire logic [3:0]  i_y,
    input  wire logic [3:0]  i_z,
    input  wire logic [14:0] i_state_id,
    output logic             o_valid,
    output logic [14:0]      o_read_state,
    output logic [3:0]       o_entry_bits,
    output logic             o_direct_mode,
    output logic [8:0]       o_palette_count
);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_ADDR   = 10'b0000000100,
        S_OFF    = 10'b0000001000,
        S_MOD    = 10'b0000010000,
        S_PAL    = 10'b0000100000,
        S_SRCH   = 10'b0001000000,
        S_CMP    = 10'b0010000000,
        S_APPEND = 10'b0100000000,
        S_REPACK = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic                               r_func, n_func;
    logic [pbvs_pkg::CELL_W-1:0]        r_idx, n_idx;
    logic [pbvs_pkg::SID_W-1:0]         r_sid, n_sid;
    logic [pbvs_pkg::SID_W-1:0]         r_val, n_val;
    logic [pbvs_pkg::WADDR_W-1:0]       r_word, n_word;
    logic [pbvs_pkg::OFF_W-1:0]         r_off, n_off;
    logic [pbvs_pkg::SID_W-1:0]         r_rd, n_rd;
    logic [pbvs_pkg::BITS_W-1:0]        r_bits, n_bits;
    logic [pbvs_pkg::BITS_W-1:0]        r_new_bits, n_new_bits;
    logic                               r_direct, n_direct;
    logic                               r_resolve, n_resolve;
    logic [pbvs_pkg::PSIZE_W-1:0]       r_psize, n_psize;
    logic                               r_bank, n_bank;
    logic [pbvs_pkg::PAL_W-1:0]         r_k, n_k;
    logic [pbvs_pkg::PAL_W-1:0]         r_clr, n_clr;
    logic                               r_valid, n_valid;

    logic                               w_we;
    logic [pbvs_pkg::MADDR_W-1:0]       w_waddr;
    logic [pbvs_pkg::WORD_W-1:0]        w_wdata;
    logic [pbvs_pkg::MADDR_W-1:0]       w_raddr;
    logic [pbvs_pkg::WORD_W-1:0]        w_word_q;
    logic                               w_pwe;
    logic [pbvs_pkg::PAL_W-1:0]         w_pwaddr;
    logic [pbvs_pkg::SID_W-1:0]         w_pwdata;
    logic [pbvs_pkg::PAL_W-1:0]         w_praddr;
    logic [pbvs_pkg::SID_W-1:0]         w_pal_q;
    logic                               w_rp_start;
    pbvs_pkg::t_repack_cfg              w_rp_cfg;
    pbvs_pkg::t_repack_req              w_rp_req;
    logic                               w_rp_done;

    logic [30:0]                        w_prod;
    logic [14:0]                        w_wxp;
    logic [pbvs_pkg::CELL_W-1:0]        w_slot;
    logic [7:0]                         w_offp;
    logic [pbvs_pkg::WORD_W-1:0]        w_mask;
    logic [pbvs_pkg::SID_W-1:0]         w_field;
    logic [pbvs_pkg::WORD_W-1:0]        w_merged;
    logic [pbvs_pkg::PSIZE_W-1:0]       w_psize_inc;
    logic [pbvs_pkg::BITS_W-1:0]        w_need;

    pbvs_ram #(
        .WIDTH(pbvs_pkg::WORD_W),
        .DEPTH(2 * pbvs_pkg::WORD_COUNT)
    ) u_words (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_word_q)
    );

    pbvs_ram #(
        .WIDTH(pbvs_pkg::SID_W),
        .DEPTH(pbvs_pkg::PALETTE_DEPTH)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (w_pwe),
        .i_waddr(w_pwaddr),
        .i_wdata(w_pwdata),
        .i_raddr(w_praddr),
        .o_rdata(w_pal_q)
    );

    pbvs_repack u_repack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rp_start),
        .i_cfg   (w_rp_cfg),
        .i_word_q(w_word_q),
        .i_pal_q (w_pal_q),
        .o_req   (w_rp_req),
        .o_done  (w_rp_done)
    );

    always_comb begin
        w_prod      = 31'(r_idx) * 31'(pbvs_pkg::word_recip(r_bits));
        w_wxp       = 15'(r_word) * 15'(pbvs_pkg::cells_per_word(r_bits));
        w_slot      = r_idx - w_wxp[pbvs_pkg::CELL_W-1:0];
        w_offp      = w_slot[3:0] * r_bits;
        w_mask      = ~({pbvs_pkg::WORD_W{1'b1}} << r_bits);
        w_field     = pbvs_pkg::SID_W'((w_word_q >> r_off) & w_mask);
        w_merged    = (w_word_q & ~(w_mask << r_off))
                    | ((pbvs_pkg::WORD_W'(r_val) & w_mask) << r_off);
        w_psize_inc = r_psize + 1'b1;
        w_need      = pbvs_pkg::need_bits(w_psize_inc);
    end

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_idx      = r_idx;
        n_sid      = r_sid;
        n_val      = r_val;
        n_word     = r_word;
        n_off      = r_off;
        n_rd       = r_rd;
        n_bits     = r_bits;
        n_new_bits = r_new_bits;
        n_direct   = r_direct;
        n_resolve  = r_resolve;
        n_psize    = r_psize;
        n_bank     = r_bank;
        n_k        = r_k;
        n_clr      = r_clr;
        n_valid    = 1'b0;

        w_we       = 1'b0;
        w_waddr    = {r_bank, r_word};
        w_wdata    = w_merged;
        w_raddr    = {r_bank, r_word};
        w_pwe      = 1'b0;
        w_pwaddr   = r_psize[pbvs_pkg::PAL_W-1:0];
        w_pwdata   = r_sid;
        w_praddr   = r_k;
        w_rp_start = 1'b0;
        w_rp_cfg.src_bits = r_bits;
        w_rp_cfg.dst_bits = r_new_bits;
        w_rp_cfg.resolve  = r_resolve;
        w_rp_cfg.src_bank = r_bank;
        w_rp_cfg.psize    = r_psize;

        case (r_state)
            S_CLEAR: begin
                w_we     = 1'b1;
                w_waddr  = {1'b0, pbvs_pkg::WADDR_W'(r_clr)};
                w_wdata  = '0;
                w_pwe    = 1'b1;
                w_pwaddr = '0;
                w_pwdata = '0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == pbvs_pkg::PAL_W'(pbvs_pkg::CLEAR_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_func  = i_func;
                    n_idx   = {i_y, i_z, i_x};
                    n_sid   = i_state_id;
                    n_val   = i_state_id;
                    n_rd    = '0;
                    n_k     = '0;
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_word = w_prod[pbvs_pkg::RECIP_SHIFT +: pbvs_pkg::WADDR_W];
                if (r_func && !r_direct) begin
                    n_state = S_SRCH;
                end else begin
                    n_state = S_OFF;
                end
            end
            S_OFF: begin
                n_off   = w_offp[pbvs_pkg::OFF_W-1:0];
                n_state = S_MOD;
            end
            S_MOD: begin
                if (r_func) begin
                    w_we    = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (r_direct) begin
                    n_rd    = w_field;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (pbvs_pkg::PSIZE_W'(w_field) < r_psize) begin
                    w_praddr = w_field[pbvs_pkg::PAL_W-1:0];
                    n_state  = S_PAL;
                end else begin
                    n_rd    = '0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PAL: begin
                n_rd    = w_pal_q;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_SRCH: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_pal_q == r_sid) begin
                    n_val   = pbvs_pkg::SID_W'(r_k);
                    n_state = S_OFF;
                end else if (pbvs_pkg::PSIZE_W'(r_k) + 1'b1 == r_psize) begin
                    n_state = S_APPEND;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SRCH;
                end
            end
            S_APPEND: begin
                if (r_psize == pbvs_pkg::PSIZE_W'(pbvs_pkg::PALETTE_DEPTH)) begin
                    n_val      = r_sid;
                    n_new_bits = pbvs_pkg::DIRECT_BITS;
                    n_resolve  = 1'b1;
                    n_state    = S_REPACK;
                end else begin
                    w_pwe   = 1'b1;
                    n_psize = w_psize_inc;
                    n_val   = pbvs_pkg::SID_W'(r_psize);
                    if (w_need > r_bits) begin
                        n_new_bits = w_need;
                        n_resolve  = 1'b0;
                        n_state    = S_REPACK;
                    end else begin
                        n_state = S_OFF;
                    end
                end
                w_rp_cfg.dst_bits = n_new_bits;
                w_rp_cfg.resolve  = n_resolve;
                w_rp_start        = (n_state == S_REPACK);
            end
            S_REPACK: begin
                w_we     = w_rp_req.wr_en;
                w_waddr  = w_rp_req.wr_addr;
                w_wdata  = w_rp_req.wr_data;
                w_raddr  = w_rp_req.rd_addr;
                w_praddr = w_rp_req.pal_addr;
                if (w_rp_done) begin
                    n_bank  = ~r_bank;
                    n_bits  = r_new_bits;
                    if (r_resolve) begin
                        n_direct = 1'b1;
                        n_psize  = '0;
                    end
                    n_state = S_ADDR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_bits   <= pbvs_pkg::MIN_BITS;
            r_direct <= 1'b0;
            r_psize  <= 9'd1;
            r_bank   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_bits   <= n_bits;
            r_direct <= n_direct;
            r_psize  <= n_psize;
            r_bank   <= n_bank;
            r_valid  <= n_valid;
        end
        r_func     <= n_func;
        r_idx      <= n_idx;
        r_sid      <= n_sid;
        r_val      <= n_val;
        r_word     <= n_word;
        r_off      <= n_off;
        r_rd       <= n_rd;
        r_new_bits <= n_new_bits;
        r_resolve  <= n_resolve;
        r_k        <= n_k;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_read_state    = r_rd;
    assign o_entry_bits    = r_bits;
    assign o_direct_mode   = r_direct;
    assign o_palette_count = r_psize;

endmodule
`default_nettype wire
